FILE: rtl/core/tce_pkg.sv
`default_nettype none
package tce_pkg;

    localparam int POS_W  = 11;
    localparam int IDX_W  = 11;

    localparam logic [7:0] DEFAULT_ATTR_RST = 8'h07;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] FINAL_LO  = 8'h41;
    localparam logic [7:0] FINAL_HI  = 8'h7D;

    localparam logic [7:0] MASK_HI   = 8'hF0;
    localparam logic [7:0] MASK_LO   = 8'h0F;
    localparam logic [7:0] BOLD_BIT  = 8'h08;

    localparam logic [7:0] SGR_RESET = 8'd0;
    localparam logic [7:0] SGR_BOLD  = 8'd1;
    localparam logic [7:0] SGR_FG_LO = 8'd30;
    localparam logic [7:0] SGR_FG_HI = 8'd37;
    localparam logic [7:0] SGR_BG_LO = 8'd40;
    localparam logic [7:0] SGR_BG_HI = 8'd47;

    localparam logic [1:0] ESC_TEXT = 2'd0;
    localparam logic [1:0] ESC_SEEN = 2'd1;
    localparam logic [1:0] ESC_CSI  = 2'd2;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [7:0]       data;
        logic [IDX_W-1:0] idx;
        logic             oor;
    } t_item;

    function automatic logic [2:0] ansi_color(input logic [2:0] c);
        logic [2:0] r;
        case (c)
            3'd0: r = 3'd0;
            3'd1: r = 3'd4;
            3'd2: r = 3'd2;
            3'd3: r = 3'd6;
            3'd4: r = 3'd1;
            3'd5: r = 3'd5;
            3'd6: r = 3'd3;
            default: r = 3'd7;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] sgr_apply(input logic [7:0] code,
                                             input logic [7:0] cur,
                                             input logic [7:0] sav);
        logic [7:0] r;
        logic [7:0] off;
        r   = cur;
        off = 8'd0;
        if (code == SGR_RESET) begin
            r = sav;
        end else if (code == SGR_BOLD) begin
            r = cur | BOLD_BIT;
        end else if (code >= SGR_FG_LO && code <= SGR_FG_HI) begin
            off = code - SGR_FG_LO;
            r = (cur & MASK_HI) | {5'd0, ansi_color(off[2:0])};
        end else if (code >= SGR_BG_LO && code <= SGR_BG_HI) begin
            off = code - SGR_BG_LO;
            r = (cur & MASK_LO) | {1'b0, ansi_color(off[2:0]), 4'd0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/tce_front.sv
`default_nettype none
module tce_front #(
    parameter int CELLS = 2000
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire                          i_cmd,
    input  wire  [7:0]                   i_data_byte,
    input  wire  [tce_pkg::IDX_W-1:0]    i_cell_index,
    output tce_pkg::t_item               o_item,
    output logic                         o_item_valid,
    input  wire                          i_pop
);
    tce_pkg::t_item r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    tce_pkg::t_item cls;

    // classify on entry: read range check done here
    always_comb begin
        cls.cmd  = i_cmd;
        cls.data = i_data_byte;
        cls.idx  = i_cell_index;
        cls.oor  = (32'(i_cell_index) >= 32'(CELLS));
    end

    assign o_in_stall   = (r_cnt == 2'd2);
    assign push         = i_in_valid && !o_in_stall;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/tce_back.sv
`default_nettype none
module tce_back #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [7:0]                   i_cfg_data,
    input  tce_pkg::t_item               i_item,
    input  wire                          i_item_valid,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [7:0]                   o_cell_char,
    output logic [7:0]                   o_cell_attr,
    output logic [tce_pkg::POS_W-1:0]    o_cursor_position,
    output logic [7:0]                   o_attribute_now
);
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int TW    = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int PW    = tce_pkg::POS_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OUT  = 3'd1;
    localparam logic [2:0] S_SRD  = 3'd2;
    localparam logic [2:0] S_SWR  = 3'd3;
    localparam logic [2:0] S_FILL = 3'd4;

    logic [15:0]   mem [CELLS];
    logic [15:0]   r_q;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic [7:0]    r_fill_attr, n_fill_attr;
    logic          r_emit, n_emit;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [TW-1:0] r_ph, n_ph;
    logic [7:0]    r_cur, n_cur, r_sav, n_sav, r_abs, n_abs;
    logic [1:0]    r_esc, n_esc;
    logic [7:0]    r_sgr, n_sgr;
    logic          r_rd_cmd, n_rd_cmd, r_rd_oor, n_rd_oor;

    logic          we, re;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wdata;

    logic [AW-1:0] pos;
    logic [7:0]    b;
    logic          do_plain, nl, go_scroll, go_clr;
    logic          dec_wr;
    logic [AW-1:0] dec_waddr;
    logic [7:0]    dec_wch;
    logic [7:0]    a_p;
    logic [7:0]    tcol;
    logic [11:0]   digit_v;
    logic          take_item, out_load;

    assign pos = AW'(r_col) + AW'(r_row) * AW'(COLUMNS);
    assign b   = i_item.data;

    // put decode: escape parser plus control bytes
    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_ph      = r_ph;
        n_cur     = r_cur;
        n_sav     = r_sav;
        n_abs     = r_abs;
        n_esc     = r_esc;
        n_sgr     = r_sgr;
        do_plain  = 1'b0;
        nl        = 1'b0;
        go_scroll = 1'b0;
        go_clr    = 1'b0;
        dec_wr    = 1'b0;
        dec_waddr = pos;
        dec_wch   = 8'd0;
        a_p       = r_cur;
        tcol      = 8'(r_col) + 8'(TAB_STOP) - 8'(r_ph);
        digit_v   = 12'(r_sgr) * 12'd10 + 12'(b - tce_pkg::CH_ZERO);
        case (r_esc)
            tce_pkg::ESC_SEEN: begin
                if (b == tce_pkg::CH_LBRK) begin
                    n_esc = tce_pkg::ESC_CSI;
                    n_sgr = 8'd0;
                    n_abs = r_cur;
                end else begin
                    n_esc    = tce_pkg::ESC_TEXT;
                    do_plain = 1'b1;
                end
            end
            tce_pkg::ESC_CSI: begin
                if (b >= tce_pkg::FINAL_LO && b <= tce_pkg::FINAL_HI) begin
                    n_esc = tce_pkg::ESC_TEXT;
                    n_sgr = 8'd0;
                    if (b == tce_pkg::CH_M) begin
                        n_cur = tce_pkg::sgr_apply(r_sgr, r_cur, r_sav);
                        n_sav = r_abs;
                    end else begin
                        n_cur = r_abs;
                        if (b == tce_pkg::CH_J) begin
                            go_clr = 1'b1;
                            n_col  = '0;
                            n_row  = '0;
                            n_ph   = '0;
                        end
                    end
                end else if (b == tce_pkg::CH_NUL) begin
                    n_esc    = tce_pkg::ESC_TEXT;
                    n_sgr    = 8'd0;
                    n_cur    = r_abs;
                    a_p      = r_abs;
                    do_plain = 1'b1;
                end else if (b >= tce_pkg::CH_ZERO && b <= tce_pkg::CH_NINE) begin
                    n_sgr = (digit_v > 12'd255) ? 8'd255 : digit_v[7:0];
                end else begin
                    n_cur = tce_pkg::sgr_apply(r_sgr, r_cur, r_sav);
                    n_sgr = 8'd0;
                end
            end
            default: begin
                n_esc    = tce_pkg::ESC_TEXT;
                do_plain = 1'b1;
            end
        endcase
        if (do_plain) begin
            case (b)
                tce_pkg::CH_ESC: n_esc = tce_pkg::ESC_SEEN;
                tce_pkg::CH_LF:  nl = 1'b1;
                tce_pkg::CH_CR: begin
                    n_col = '0;
                    n_ph  = '0;
                end
                tce_pkg::CH_BS: begin
                    if (r_col != '0) begin
                        n_col     = r_col - CW'(1);
                        n_ph      = (r_ph == '0) ? TW'(TAB_STOP - 1) : r_ph - TW'(1);
                        dec_wr    = 1'b1;
                        dec_waddr = pos - AW'(1);
                        dec_wch   = 8'd0;
                    end
                end
                tce_pkg::CH_TAB: begin
                    if (tcol >= 8'(COLUMNS)) begin
                        nl = 1'b1;
                    end else begin
                        n_col = CW'(tcol);
                        n_ph  = '0;
                    end
                end
                default: begin
                    dec_wr  = 1'b1;
                    dec_wch = b;
                    if (32'(r_col) == 32'(COLUMNS - 1)) begin
                        nl = 1'b1;
                    end else begin
                        n_col = r_col + CW'(1);
                        n_ph  = (32'(r_ph) == 32'(TAB_STOP - 1)) ? '0 : r_ph + TW'(1);
                    end
                end
            endcase
        end
        if (nl) begin
            n_col = '0;
            n_ph  = '0;
            if (32'(r_row) == 32'(ROWS - 1)) begin
                go_scroll = 1'b1;
            end else begin
                n_row = r_row + RW'(1);
            end
        end
    end

    assign take_item = (r_state == S_IDLE) && i_item_valid;
    assign o_pop     = take_item;
    assign out_load  = (r_state == S_OUT) && (!o_out_valid || !i_out_stall);

    // buffer port control
    always_comb begin
        we    = 1'b0;
        waddr = r_addr;
        wdata = {8'd0, r_fill_attr};
        re    = 1'b0;
        raddr = AW'(i_item.idx);
        case (r_state)
            S_IDLE: begin
                if (take_item) begin
                    if (i_item.cmd == tce_pkg::CMD_READ) begin
                        re = !i_item.oor;
                    end else begin
                        we    = dec_wr;
                        waddr = dec_waddr;
                        wdata = {dec_wch, a_p};
                    end
                end
            end
            S_SRD: begin
                re    = 1'b1;
                raddr = r_addr + AW'(COLUMNS);
            end
            S_SWR: begin
                we    = 1'b1;
                wdata = r_q;
            end
            S_FILL: we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_q <= mem[raddr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_fill_attr = r_fill_attr;
        n_emit      = r_emit;
        n_rd_cmd    = r_rd_cmd;
        n_rd_oor    = r_rd_oor;
        case (r_state)
            S_IDLE: begin
                if (take_item) begin
                    n_rd_cmd = i_item.cmd;
                    n_rd_oor = i_item.oor;
                    n_emit   = 1'b1;
                    n_addr   = '0;
                    n_fill_attr = n_cur;
                    if (i_item.cmd == tce_pkg::CMD_PUT && go_scroll) begin
                        n_state = S_SRD;
                    end else if (i_item.cmd == tce_pkg::CMD_PUT && go_clr) begin
                        n_state = S_FILL;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SRD: n_state = S_SWR;
            S_SWR: begin
                n_addr  = r_addr + AW'(1);
                n_state = (32'(r_addr) == 32'(CELLS - COLUMNS - 1)) ? S_FILL : S_SRD;
            end
            S_FILL: begin
                if (32'(r_addr) == 32'(CELLS - 1)) begin
                    n_state = r_emit ? S_OUT : S_IDLE;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_addr      <= '0;
            r_fill_attr <= tce_pkg::DEFAULT_ATTR_RST;
            r_emit      <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_ph        <= '0;
            r_cur       <= tce_pkg::DEFAULT_ATTR_RST;
            r_sav       <= tce_pkg::DEFAULT_ATTR_RST;
            r_abs       <= tce_pkg::DEFAULT_ATTR_RST;
            r_esc       <= tce_pkg::ESC_TEXT;
            r_sgr       <= 8'd0;
            r_rd_cmd    <= 1'b0;
            r_rd_oor    <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_fill_attr <= n_fill_attr;
            r_emit      <= n_emit;
            r_rd_cmd    <= n_rd_cmd;
            r_rd_oor    <= n_rd_oor;
            if (take_item && i_item.cmd == tce_pkg::CMD_PUT) begin
                r_col <= n_col;
                r_row <= n_row;
                r_ph  <= n_ph;
                r_cur <= n_cur;
                r_sav <= n_sav;
                r_abs <= n_abs;
                r_esc <= n_esc;
                r_sgr <= n_sgr;
            end
            if (i_cfg_we) begin
                r_cur <= i_cfg_data;
                r_sav <= i_cfg_data;
                r_abs <= i_cfg_data;
            end
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_cell_char       <= (r_rd_cmd && !r_rd_oor) ? r_q[15:8] : 8'd0;
            o_cell_attr       <= (r_rd_cmd && !r_rd_oor) ? r_q[7:0] : 8'd0;
            o_cursor_position <= PW'(pos);
            o_attribute_now   <= r_cur;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/text_console_engine.sv
// Text console: a COLUMNS x ROWS buffer of char/attribute cells fed one byte
// item at a time (cmd 0) or read one cell at a time (cmd 1). Each item gives one
// result. A 2-entry input queue takes items while the back end works; the back
// end takes a new item only once the last one's result is loaded for output.
// A plain byte, control byte or cell read passes through the idle and output
// states; the buffer RAM has a single write port and a single read port. A
// scroll copies the buffer up one row, reading and then writing each cell, then
// blanks the bottom row; ESC [ J clears all COLUMNS*ROWS cells. After reset a
// clearing pass fills the buffer with attribute 7; items queue up meanwhile,
// config writes are taken at once.
`default_nettype none
module text_console_engine #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire  [7:0]                   i_cfg_data,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire                          i_cmd,
    input  wire  [7:0]                   i_data_byte,
    input  wire  [tce_pkg::IDX_W-1:0]    i_cell_index,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [7:0]                   o_cell_char,
    output logic [7:0]                   o_cell_attr,
    output logic [tce_pkg::POS_W-1:0]    o_cursor_position,
    output logic [7:0]                   o_attribute_now
);
    tce_pkg::t_item item;
    logic           item_valid, pop;

    tce_front #(.CELLS(COLUMNS * ROWS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_data_byte  (i_data_byte),
        .i_cell_index (i_cell_index),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_pop        (pop)
    );

    tce_back #(.COLUMNS(COLUMNS), .ROWS(ROWS), .TAB_STOP(TAB_STOP)) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_item            (item),
        .i_item_valid      (item_valid),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_cell_char       (o_cell_char),
        .o_cell_attr       (o_cell_attr),
        .o_cursor_position (o_cursor_position),
        .o_attribute_now   (o_attribute_now)
    );
endmodule
`default_nettype wire

FILE: rtl/core/tce_checker.sv
`default_nettype none
module tce_checker #(
    parameter int CELLS = 2000
) (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [7:0]  o_cell_char,
    input wire [7:0]  o_cell_attr,
    input wire [10:0] o_cursor_position,
    input wire [7:0]  o_attribute_now
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid
            && $stable({o_cell_char, o_cell_attr, o_cursor_position, o_attribute_now}))
        else $error("result changed while stalled");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (CELLS > 2047) || (32'(o_cursor_position) < 32'(CELLS)))
        else $error("cursor outside buffer");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");
endmodule

bind text_console_engine tce_checker #(.CELLS(COLUMNS * ROWS)) u_tce_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_cell_char       (o_cell_char),
    .o_cell_attr       (o_cell_attr),
    .o_cursor_position (o_cursor_position),
    .o_attribute_now   (o_attribute_now)
);
`default_nettype wire

FILE: tb/text_console_engine_test.sv
`default_nettype none
module text_console_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS  = 80;
    localparam int LINES = 25;
    localparam int TABW  = 8;
    localparam int CELLS = COLS * LINES;

    typedef struct {
        logic                      cmd;
        logic [7:0]                data;
        logic [tce_pkg::IDX_W-1:0] idx;
    } t_stim;

    typedef struct {
        logic [7:0]                ch;
        logic [7:0]                at;
        logic [tce_pkg::POS_W-1:0] pos;
        logic [7:0]                attr;
    } t_reply;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_we = 1'b0;
    logic [7:0]                i_cfg_data = 8'h00;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic                      i_cmd = tce_pkg::CMD_PUT;
    logic [7:0]                i_data_byte = 8'h00;
    logic [tce_pkg::IDX_W-1:0] i_cell_index = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [7:0]                o_cell_char;
    logic [7:0]                o_cell_attr;
    logic [tce_pkg::POS_W-1:0] o_cursor_position;
    logic [7:0]                o_attribute_now;

    text_console_engine dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_cmd             (i_cmd),
        .i_data_byte       (i_data_byte),
        .i_cell_index      (i_cell_index),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_cell_char       (o_cell_char),
        .o_cell_attr       (o_cell_attr),
        .o_cursor_position (o_cursor_position),
        .o_attribute_now   (o_attribute_now)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shadow console state
    logic [7:0] scr_ch [CELLS];
    logic [7:0] scr_at [CELLS];
    int         cur_col, cur_row;
    logic [7:0] dflt_attr, cur_attr, sav_attr, pre_attr;
    logic [1:0] esc_st;
    logic [7:0] sgr_acc;

    t_stim  pending_q[$];
    t_reply cell_reply_q[$];
    t_stim  drv_item;
    logic   in_taken = 1'b0;
    int     n_queued = 0, n_taken = 0, n_reads = 0, n_scrolls = 0, n_clears = 0;
    int     n_bad = 0;
    int     n_results = 0;

    function automatic logic [2:0] vga_color(input int c);
        case (c)
            1: return 3'd4;
            3: return 3'd6;
            4: return 3'd1;
            6: return 3'd3;
            default: return c[2:0];
        endcase
    endfunction

    task automatic blank_from(input int from, input logic [7:0] a);
        for (int i = from; i < CELLS; i++) begin
            scr_ch[i] = 8'h00;
            scr_at[i] = a;
        end
    endtask

    task automatic line_feed();
        cur_col = 0;
        cur_row++;
        if (cur_row >= LINES) begin
            for (int i = 0; i < CELLS - COLS; i++) begin
                scr_ch[i] = scr_ch[i + COLS];
                scr_at[i] = scr_at[i + COLS];
            end
            blank_from(CELLS - COLS, cur_attr);
            cur_row = LINES - 1;
            n_scrolls++;
        end
    endtask

    task automatic put_glyph(input logic [7:0] c);
        int p;
        p = cur_col + cur_row * COLS;
        if (p < CELLS) begin
            scr_ch[p] = c;
            scr_at[p] = cur_attr;
        end
    endtask

    task automatic apply_code(input logic [7:0] code);
        if (code == tce_pkg::SGR_RESET) begin
            cur_attr = sav_attr;
        end else if (code == tce_pkg::SGR_BOLD) begin
            cur_attr = cur_attr | tce_pkg::BOLD_BIT;
        end else if (code >= tce_pkg::SGR_FG_LO && code <= tce_pkg::SGR_FG_HI) begin
            cur_attr = (cur_attr & tce_pkg::MASK_HI)
                     | {5'd0, vga_color(int'(code - tce_pkg::SGR_FG_LO))};
        end else if (code >= tce_pkg::SGR_BG_LO && code <= tce_pkg::SGR_BG_HI) begin
            cur_attr = (cur_attr & tce_pkg::MASK_LO)
                     | {1'b0, vga_color(int'(code - tce_pkg::SGR_BG_LO)), 4'd0};
        end
    endtask

    task automatic text_byte(input logic [7:0] b);
        case (b)
            tce_pkg::CH_ESC: esc_st = tce_pkg::ESC_SEEN;
            tce_pkg::CH_LF:  line_feed();
            tce_pkg::CH_CR:  cur_col = 0;
            tce_pkg::CH_BS: begin
                if (cur_col > 0) begin
                    cur_col--;
                    put_glyph(8'h00);
                end
            end
            tce_pkg::CH_TAB: begin
                cur_col = (cur_col / TABW + 1) * TABW;
                if (cur_col >= COLS) line_feed();
            end
            default: begin
                put_glyph(b);
                cur_col++;
                if (cur_col >= COLS) line_feed();
            end
        endcase
    endtask

    task automatic console_step(input t_stim s);
        t_reply r;
        int     v, p;
        r.ch = 8'h00;
        r.at = 8'h00;
        if (s.cmd == tce_pkg::CMD_READ) begin
            n_reads++;
            if (s.idx < CELLS) begin
                r.ch = scr_ch[s.idx];
                r.at = scr_at[s.idx];
            end
        end else if (esc_st == tce_pkg::ESC_SEEN) begin
            if (s.data == tce_pkg::CH_LBRK) begin
                esc_st = tce_pkg::ESC_CSI;
                sgr_acc = 8'd0;
                pre_attr = cur_attr;
            end else begin
                esc_st = tce_pkg::ESC_TEXT;
                text_byte(s.data);
            end
        end else if (esc_st == tce_pkg::ESC_CSI) begin
            if (s.data >= tce_pkg::FINAL_LO && s.data <= tce_pkg::FINAL_HI) begin
                esc_st = tce_pkg::ESC_TEXT;
                if (s.data == tce_pkg::CH_M) begin
                    apply_code(sgr_acc);
                    sav_attr = pre_attr;
                end else begin
                    cur_attr = pre_attr;
                    if (s.data == tce_pkg::CH_J) begin
                        blank_from(0, cur_attr);
                        cur_col = 0;
                        cur_row = 0;
                        n_clears++;
                    end
                end
                sgr_acc = 8'd0;
            end else if (s.data == tce_pkg::CH_NUL) begin
                esc_st = tce_pkg::ESC_TEXT;
                sgr_acc = 8'd0;
                cur_attr = pre_attr;
                text_byte(s.data);
            end else if (s.data >= tce_pkg::CH_ZERO && s.data <= tce_pkg::CH_NINE) begin
                v = int'(sgr_acc) * 10 + int'(s.data - tce_pkg::CH_ZERO);
                sgr_acc = (v > 255) ? 8'd255 : v[7:0];
            end else begin
                apply_code(sgr_acc);
                sgr_acc = 8'd0;
            end
        end else begin
            esc_st = tce_pkg::ESC_TEXT;
            text_byte(s.data);
        end
        p = cur_col + cur_row * COLS;
        r.pos = p[tce_pkg::POS_W-1:0];
        r.attr = cur_attr;
        cell_reply_q.push_back(r);
    endtask

    task automatic push_put(input logic [7:0] b);
        t_stim s;
        s.cmd = tce_pkg::CMD_PUT;
        s.data = b;
        s.idx = tce_pkg::IDX_W'($urandom);
        pending_q.push_back(s);
        n_queued++;
    endtask

    task automatic push_read(input int idx);
        t_stim s;
        s.cmd = tce_pkg::CMD_READ;
        s.data = 8'($urandom);
        s.idx = idx[tce_pkg::IDX_W-1:0];
        pending_q.push_back(s);
        n_queued++;
    endtask

    task automatic push_digits(input int v);
        if (v >= 10) push_digits(v / 10);
        push_put(tce_pkg::CH_ZERO + 8'(v % 10));
    endtask

    function automatic int pick_code();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 0;
        if (k == 1) return 1;
        if (k < 5) return $urandom_range(30, 37);
        if (k < 8) return $urandom_range(40, 47);
        if (k == 8) return $urandom_range(0, 99);
        return $urandom_range(200, 99999);
    endfunction

    // mostly text plus cell reads, with well-formed escape sequences, some noise and broken ones
    task automatic push_random(input int n);
        int target, k, np;
        target = n_queued + n;
        while (n_queued < target) begin
            k = $urandom_range(0, 99);
            if (k < 45) begin
                push_put(8'($urandom_range(32, 126)));
            end else if (k < 60) begin
                push_read($urandom_range(0, 2047));
            end else if (k < 63) begin
                push_put(tce_pkg::CH_LF);
            end else if (k < 65) begin
                push_put(tce_pkg::CH_CR);
            end else if (k < 68) begin
                push_put(tce_pkg::CH_BS);
            end else if (k < 71) begin
                push_put(tce_pkg::CH_TAB);
            end else if (k < 75) begin
                push_put(8'($urandom));
            end else if (k < 91) begin
                push_put(tce_pkg::CH_ESC);
                push_put(tce_pkg::CH_LBRK);
                np = $urandom_range(0, 3);
                for (int i = 0; i < np; i++) begin
                    if ($urandom_range(0, 5) != 0) push_digits(pick_code());
                    if (i < np - 1) push_put(($urandom_range(0, 7) == 0) ? 8'h3A : 8'h3B);
                end
                k = $urandom_range(0, 99);
                if (k < 80) push_put(tce_pkg::CH_M);
                else if (k < 82) push_put(tce_pkg::CH_J);
                else if (k < 90) push_put(8'($urandom_range(int'(tce_pkg::FINAL_LO),
                                                            int'(tce_pkg::FINAL_HI))));
                else if (k < 95) push_put(tce_pkg::CH_NUL);
                else push_put(8'($urandom_range(32, 255)));
            end else if (k < 95) begin
                push_put(tce_pkg::CH_ESC);
                push_put(8'($urandom));
            end else begin
                push_put(tce_pkg::CH_ESC);
                push_put(tce_pkg::CH_LBRK);
                push_put(8'($urandom));
            end
        end
    endtask

    function automatic logic roll_idle();
        if (n_taken >= 350 && n_taken < 500) return 1'b0;
        return $urandom_range(0, 99) < 31;
    endfunction

    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            console_step(drv_item);
            n_taken++;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (pending_q.size() > 0 && !roll_idle()) begin
                    drv_item = pending_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_cmd <= drv_item.cmd;
                    i_data_byte <= drv_item.data;
                    i_cell_index <= drv_item.idx;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= roll_idle();
        end
    end

    always @(posedge i_clk) begin
        t_reply w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (cell_reply_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result at %0t", $realtime);
            end else begin
                w = cell_reply_q.pop_front();
                if (o_cell_char !== w.ch || o_cell_attr !== w.at ||
                    o_cursor_position !== w.pos || o_attribute_now !== w.attr) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch result %0d: char %h/%h attr %h/%h pos %0d/%0d cur %h/%h",
                                 n_results, o_cell_char, w.ch, o_cell_attr, w.at,
                                 o_cursor_position, w.pos, o_attribute_now, w.attr);
                end
            end
        end
    end

    task automatic drain();
        while (pending_q.size() > 0 || i_in_valid || cell_reply_q.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_default(input logic [7:0] a);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= a;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        dflt_attr = a;
        cur_attr = a;
        sav_attr = a;
        pre_attr = a;
    endtask

    initial begin
        dflt_attr = tce_pkg::DEFAULT_ATTR_RST;
        blank_from(0, dflt_attr);
        cur_col = 0;
        cur_row = 0;
        cur_attr = dflt_attr;
        sav_attr = dflt_attr;
        pre_attr = dflt_attr;
        esc_st = tce_pkg::ESC_TEXT;
        sgr_acc = 8'd0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: control bytes, sgr codes, saturation, aborted and odd sequences, cell reads
        push_put(tce_pkg::CH_BS);
        push_put(8'hFF);
        push_put(tce_pkg::FINAL_LO);
        push_put(tce_pkg::CH_TAB);
        push_put(tce_pkg::CH_BS);
        push_put(tce_pkg::CH_LF);
        push_put(tce_pkg::CH_CR);
        push_put(tce_pkg::CH_ESC); push_put(tce_pkg::CH_LBRK); push_put(8'h31);
        push_put(8'h3B);
        push_put(8'h33); push_put(8'h31); push_put(8'h3B); push_put(8'h34);
        push_put(8'h32); push_put(tce_pkg::CH_M);
        push_put(8'h41);
        push_put(tce_pkg::CH_ESC); push_put(tce_pkg::CH_LBRK); push_digits(999);
        push_put(tce_pkg::CH_M);
        push_put(tce_pkg::CH_ESC); push_put(tce_pkg::CH_LBRK); push_put(tce_pkg::CH_M);
        push_put(tce_pkg::CH_ESC); push_put(tce_pkg::CH_ESC); push_put(8'h78);
        push_put(tce_pkg::CH_ESC); push_put(tce_pkg::CH_LBRK); push_put(8'h33);
        push_put(tce_pkg::CH_NUL);
        push_put(tce_pkg::CH_ESC); push_put(tce_pkg::CH_LBRK); push_put(8'h48);
        push_read(0); push_read(1); push_read(CELLS - 1); push_read(CELLS);
        push_read(2047);
        drain();

        set_default(8'h00);
        push_random(150);
        drain();

        set_default(8'hFF);
        push_put(tce_pkg::CH_ESC); push_put(tce_pkg::CH_LBRK); push_put(tce_pkg::CH_J);
        push_random(250);
        drain();

        set_default(8'($urandom));
        push_random(300);
        drain();

        set_default(tce_pkg::DEFAULT_ATTR_RST);
        push_random(150);
        drain();
        repeat (200) @(posedge i_clk);

        $display("%0d items (%0d cell reads), %0d scrolls, %0d screen clears, 4 attribute settings",
                 n_taken, n_reads, n_scrolls, n_clears);
        if (n_bad == 0) begin
            $display("PASS text_console_engine");
        end else begin
            $display("%0d mismatches", n_bad);
            $display("FAIL text_console_engine");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout");
        $display("FAIL text_console_engine");
        $finish;
    end

endmodule
`default_nettype wire
